### src/tlse_pkg.sv
// Shared codes and node tables for the triangle Lagrange shape evaluator.
// Holds element order codes, node kinds, rounding shift codes and the stage
// control struct. Depends on nothing.
package tlse_pkg;

    // Effective element order
    localparam logic [1:0] ORDER_LINEAR = 2'd1;
    localparam logic [1:0] ORDER_QUAD   = 2'd2;
    localparam logic [1:0] ORDER_CUBIC  = 2'd3;

    // Kind of node being evaluated
    localparam logic [2:0] KIND_LIN_VTX   = 3'd0;
    localparam logic [2:0] KIND_QUAD_VTX  = 3'd1;
    localparam logic [2:0] KIND_QUAD_EDGE = 3'd2;
    localparam logic [2:0] KIND_CUB_VTX   = 3'd3;
    localparam logic [2:0] KIND_CUB_EDGE  = 3'd4;
    localparam logic [2:0] KIND_CENTRE    = 3'd5;

    // Rounding shift applied to a product
    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_F    = 2'd1;
    localparam logic [1:0] SH_F1   = 2'd2;

    localparam logic [3:0] NODE_CENTRE = 4'd9;

    // Control that travels with one node through the back pipeline
    typedef struct packed {
        logic [1:0] sh1;
        logic [1:0] sh2;
        logic [1:0] sh3;
        logic [1:0] sh4;
        logic       pre9;
        logic       gadd;
        logic       mul27;
        logic       centre;
        logic [1:0] idx_a;
        logic [1:0] idx_b;
        logic [3:0] node;
        logic       last;
    } node_ctl_t;

    // Number of nodes for an effective order
    function automatic logic [3:0] node_count(input logic [1:0] ord);
        unique case (ord)
            ORDER_LINEAR: node_count = 4'd3;
            ORDER_QUAD:   node_count = 4'd6;
            default:      node_count = 4'd10;
        endcase
    endfunction

    // Node kind from order and node number
    function automatic logic [2:0] node_kind(input logic [1:0] ord, input logic [3:0] k);
        priority if (k < 4'd3) begin
            unique case (ord)
                ORDER_LINEAR: node_kind = KIND_LIN_VTX;
                ORDER_QUAD:   node_kind = KIND_QUAD_VTX;
                default:      node_kind = KIND_CUB_VTX;
            endcase
        end else if (ord == ORDER_QUAD) begin
            node_kind = KIND_QUAD_EDGE;
        end else if (k == NODE_CENTRE) begin
            node_kind = KIND_CENTRE;
        end else begin
            node_kind = KIND_CUB_EDGE;
        end
    endfunction

    // First area coordinate of a node
    function automatic logic [1:0] node_a(input logic [1:0] ord, input logic [3:0] k);
        node_a = 2'd0;
        if (k < 4'd3) begin
            node_a = k[1:0];
        end else if (ord == ORDER_QUAD) begin
            unique case (k)
                4'd3:    node_a = 2'd0;
                4'd4:    node_a = 2'd1;
                default: node_a = 2'd2;
            endcase
        end else begin
            unique case (k)
                4'd3:    node_a = 2'd0;
                4'd4:    node_a = 2'd1;
                4'd5:    node_a = 2'd1;
                4'd6:    node_a = 2'd2;
                4'd7:    node_a = 2'd2;
                default: node_a = 2'd0;
            endcase
        end
    endfunction

    // Second area coordinate of an edge node
    function automatic logic [1:0] node_b(input logic [1:0] ord, input logic [3:0] k);
        node_b = 2'd0;
        if (k < 4'd3) begin
            node_b = k[1:0];
        end else if (ord == ORDER_QUAD) begin
            unique case (k)
                4'd3:    node_b = 2'd1;
                4'd4:    node_b = 2'd2;
                default: node_b = 2'd0;
            endcase
        end else begin
            unique case (k)
                4'd3:    node_b = 2'd1;
                4'd4:    node_b = 2'd0;
                4'd5:    node_b = 2'd2;
                4'd6:    node_b = 2'd1;
                4'd7:    node_b = 2'd0;
                default: node_b = 2'd2;
            endcase
        end
    endfunction

endpackage

### src/tlse_queue.sv
// Two-entry queue between the front and the back of the evaluator.
// Generic payload width; uses no package.
module tlse_queue #(
    parameter int W = 60
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);

    logic [W-1:0] mem [2];
    logic         wptr_reg, wptr_next;
    logic         rptr_reg, rptr_next;
    logic [1:0]   count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = mem[rptr_reg];

    // Pointer and fill count update
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = ~wptr_reg;
        end
        if (pop) begin
            rptr_next = ~rptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= wdata;
        end
    end

endmodule

### src/tlse_front.sv
// Front end: accepts point beats, forms the three area coordinates and the
// effective element order, and pushes them into the queue. Uses tlse_pkg.
module tlse_front #(
    parameter int FRAC_BITS = 16,
    parameter int EW        = 60
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [39:0]   s_axis_tdata,
    input  logic          q_full,
    output logic          q_push,
    output logic [EW-1:0] q_wdata
);

    localparam int LW = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;

    logic [1:0]           order_reg, order_next;
    logic [1:0]           eff_order;
    logic signed [17:0]   coord0, coord1;
    logic signed [LW-1:0] l0, l1, l2, unit;

    // Element order register; the user must write it only while idle, the block does not enforce this
    always_comb begin
        order_next = order_reg;
        if (cfg_we) begin
            order_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= tlse_pkg::ORDER_LINEAR;
        end else begin
            order_reg <= order_next;
        end
    end

    // Order zero is treated as linear.
    assign eff_order = (order_reg == 2'd0) ? tlse_pkg::ORDER_LINEAR : order_reg;

    // Area coordinates: L3 is one minus the other two.
    assign coord0 = s_axis_tdata[17:0];
    assign coord1 = s_axis_tdata[35:18];
    assign l0     = LW'(coord0);
    assign l1     = LW'(coord1);
    assign unit   = LW'(1) <<< FRAC_BITS;
    assign l2     = unit - l0 - l1;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;
    assign q_wdata       = {l2, coord1, coord0, eff_order};

endmodule

### src/tlse_back.sv
// Back end: walks the nodes of the head point, one node per cycle unless the
// output stalls, through a multiply pipeline and drives the result channel. Uses tlse_pkg.
module tlse_back #(
    parameter int FRAC_BITS = 16,
    parameter int EW        = 60
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  logic [EW-1:0] q_rdata,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [3:0]    m_node,
    output logic [31:0]   m_shape,
    output logic [31:0]   m_deriv0,
    output logic [31:0]   m_deriv1,
    output logic          m_last
);

    localparam int LW = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;
    localparam int XW = LW + 4;
    localparam int YW = LW + 6;
    localparam int PW = XW + YW;
    localparam int RW = 2 * LW + 6 - FRAC_BITS;
    localparam int QW = RW + YW;
    localparam int VW = QW + 5;
    localparam int GW = RW + 6;

    // Round half up after a product, by none, F or F+1 bits
    function automatic logic signed [PW-1:0] rs_p(input logic signed [PW-1:0] p,
                                                  input logic [1:0] sh);
        unique case (sh)
            tlse_pkg::SH_F:  rs_p = (p + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            tlse_pkg::SH_F1: rs_p = (p + (PW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
            default:         rs_p = p;
        endcase
    endfunction

    function automatic logic signed [QW-1:0] rs_q(input logic signed [QW-1:0] p,
                                                  input logic [1:0] sh);
        unique case (sh)
            tlse_pkg::SH_F:  rs_q = (p + (QW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            tlse_pkg::SH_F1: rs_q = (p + (QW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
            default:         rs_q = p;
        endcase
    endfunction

    // Contribution of one coordinate gradient to d/dxi1 (axis 0) or d/dxi2
    function automatic logic signed [GW-1:0] gterm(input logic signed [RW-1:0] g,
                                                   input logic [1:0] idx,
                                                   input logic axis);
        unique case (idx)
            2'd0:    gterm = axis ? GW'(0) : GW'(g);
            2'd1:    gterm = axis ? GW'(g) : GW'(0);
            default: gterm = -GW'(g);
        endcase
    endfunction

    function automatic logic [31:0] sat32(input logic signed [VW-1:0] v);
        if (v[VW-1:31] == {(VW-31){v[31]}}) begin
            sat32 = v[31:0];
        end else if (v[VW-1]) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = 32'h7FFF_FFFF;
        end
    endfunction

    logic                 adv, issue;
    logic [1:0]           ord;
    logic signed [LW-1:0] l0, l1, l2, la, lb;
    logic signed [YW-1:0] la_y, lb_y, unit_y;
    logic [3:0]           cnt_reg, cnt_next;
    logic [2:0]           kind;
    logic [1:0]           idx_a, idx_b;
    tlse_pkg::node_ctl_t  ctl;
    logic signed [XW-1:0] x1, x2, x3;
    logic signed [YW-1:0] y1, y2, y3, y4;

    // Stage 1: operands
    logic                 s1_valid_reg;
    tlse_pkg::node_ctl_t  s1_ctl_reg;
    logic signed [XW-1:0] s1_x1_reg, s1_x2_reg, s1_x3_reg;
    logic signed [YW-1:0] s1_y1_reg, s1_y2_reg, s1_y3_reg, s1_y4_reg;
    // Stage 2: first products
    logic                 s2_valid_reg;
    tlse_pkg::node_ctl_t  s2_ctl_reg;
    logic signed [PW-1:0] s2_p1_reg, s2_p2_reg, s2_p3_reg;
    logic signed [YW-1:0] s2_y4_reg;
    // Stage 3: rounded terms and second product
    logic                 s3_valid_reg;
    tlse_pkg::node_ctl_t  s3_ctl_reg;
    logic signed [QW-1:0] s3_p4_reg;
    logic signed [RW-1:0] s3_r1_reg, s3_r2_reg, s3_r3_reg;
    logic signed [RW-1:0] r1, r2, r3, x4;
    // Output register
    logic                 out_valid_reg;
    logic [3:0]           out_node_reg;
    logic                 out_last_reg;
    logic [31:0]          out_shape_reg, out_d0_reg, out_d1_reg;
    logic signed [QW-1:0] vs;
    logic signed [VW-1:0] vfull, d0full, d1full;

    // The whole pipeline moves when the output register is empty or its beat is taken.
    assign adv   = !out_valid_reg || m_ready;
    assign issue = adv && !q_empty;

    assign ord = q_rdata[1:0];
    assign l0  = LW'($signed(q_rdata[19:2]));
    assign l1  = LW'($signed(q_rdata[37:20]));
    assign l2  = $signed(q_rdata[38 +: LW]);

    // Node sequencer over the head point
    always_comb begin
        cnt_next = cnt_reg;
        q_pop    = 1'b0;
        if (issue) begin
            if (cnt_reg == tlse_pkg::node_count(ord) - 4'd1) begin
                cnt_next = 4'd0;
                q_pop    = 1'b1;
            end else begin
                cnt_next = cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 4'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Coordinate selection for the node's pair
    always_comb begin
        idx_a = tlse_pkg::node_a(ord, cnt_reg);
        idx_b = tlse_pkg::node_b(ord, cnt_reg);
        unique case (idx_a)
            2'd0:    la = l0;
            2'd1:    la = l1;
            default: la = l2;
        endcase
        unique case (idx_b)
            2'd0:    lb = l0;
            2'd1:    lb = l1;
            default: lb = l2;
        endcase
    end

    assign kind   = tlse_pkg::node_kind(ord, cnt_reg);
    assign la_y   = YW'(la);
    assign lb_y   = YW'(lb);
    assign unit_y = YW'(1) <<< FRAC_BITS;

    // Operand and control setup per node kind
    always_comb begin
        ctl.idx_a  = idx_a;
        ctl.idx_b  = idx_b;
        ctl.node   = cnt_reg;
        ctl.last   = (cnt_reg == tlse_pkg::node_count(ord) - 4'd1);
        ctl.sh1    = tlse_pkg::SH_F;
        ctl.sh2    = tlse_pkg::SH_NONE;
        ctl.sh3    = tlse_pkg::SH_NONE;
        ctl.sh4    = tlse_pkg::SH_NONE;
        ctl.pre9   = 1'b0;
        ctl.gadd   = 1'b0;
        ctl.mul27  = 1'b0;
        ctl.centre = 1'b0;
        x1 = XW'(la);
        y1 = lb_y;
        x2 = XW'(1);
        y2 = YW'(0);
        x3 = XW'(0);
        y3 = YW'(0);
        y4 = YW'(1);
        unique case (kind)
            tlse_pkg::KIND_LIN_VTX: begin
                ctl.sh1 = tlse_pkg::SH_NONE;
                y1      = YW'(1);
                y2      = unit_y;
            end
            tlse_pkg::KIND_QUAD_VTX: begin
                y1 = (la_y <<< 1) - unit_y;
                y2 = (la_y <<< 2) - unit_y;
            end
            tlse_pkg::KIND_QUAD_EDGE: begin
                y4 = YW'(4);
                y2 = lb_y <<< 2;
                x3 = XW'(1);
                y3 = la_y <<< 2;
            end
            tlse_pkg::KIND_CUB_VTX: begin
                y1       = (la_y <<< 1) + la_y - unit_y;
                y4       = (la_y <<< 1) + la_y - (unit_y <<< 1);
                ctl.sh4  = tlse_pkg::SH_F1;
                x2       = XW'(la);
                y2       = (la_y <<< 4) + (la_y <<< 3) + (la_y <<< 1) + la_y
                           - (unit_y <<< 4) - (unit_y <<< 1);
                ctl.sh2  = tlse_pkg::SH_F1;
                ctl.gadd = 1'b1;
            end
            tlse_pkg::KIND_CUB_EDGE: begin
                ctl.pre9 = 1'b1;
                y4       = (la_y <<< 1) + la_y - unit_y;
                ctl.sh4  = tlse_pkg::SH_F1;
                x2       = XW'((lb_y <<< 3) + lb_y);
                y2       = (la_y <<< 2) + (la_y <<< 1) - unit_y;
                ctl.sh2  = tlse_pkg::SH_F1;
                x3       = XW'((la_y <<< 3) + la_y);
                y3       = (la_y <<< 1) + la_y - unit_y;
                ctl.sh3  = tlse_pkg::SH_F1;
            end
            tlse_pkg::KIND_CENTRE: begin
                x1         = XW'(l0);
                y1         = YW'(l1);
                y4         = YW'(l2);
                ctl.sh4    = tlse_pkg::SH_F;
                ctl.mul27  = 1'b1;
                ctl.centre = 1'b1;
                x2         = XW'(l1);
                y2         = YW'(l2);
                ctl.sh2    = tlse_pkg::SH_F;
                x3         = XW'(l0);
                y3         = YW'(l2);
                ctl.sh3    = tlse_pkg::SH_F;
            end
            default: begin
                ctl.sh1 = tlse_pkg::SH_NONE;
            end
        endcase
    end

    // Valid bits of the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Rounded first products and the second multiplier operand
    always_comb begin
        r1 = RW'(rs_p(s2_p1_reg, s2_ctl_reg.sh1));
        r2 = RW'(rs_p(s2_p2_reg, s2_ctl_reg.sh2));
        r3 = RW'(rs_p(s2_p3_reg, s2_ctl_reg.sh3));
        if (s2_ctl_reg.gadd) begin
            r2 = r2 + (RW'(1) <<< FRAC_BITS);
        end
        x4 = s2_ctl_reg.pre9 ? (r1 <<< 3) + r1 : r1;
    end

    // Final value, gradients by the chain rule, and saturation
    always_comb begin
        vs    = rs_q(s3_p4_reg, s3_ctl_reg.sh4);
        vfull = s3_ctl_reg.mul27 ? (VW'(vs) <<< 4) + (VW'(vs) <<< 3) + (VW'(vs) <<< 1)
                                   + VW'(vs)
                                 : VW'(vs);
        if (s3_ctl_reg.centre) begin
            d0full = VW'(GW'(s3_r2_reg) - GW'(s3_r1_reg)) * VW'(27);
            d1full = VW'(GW'(s3_r3_reg) - GW'(s3_r1_reg)) * VW'(27);
        end else begin
            d0full = VW'(gterm(s3_r2_reg, s3_ctl_reg.idx_a, 1'b0)
                         + gterm(s3_r3_reg, s3_ctl_reg.idx_b, 1'b0));
            d1full = VW'(gterm(s3_r2_reg, s3_ctl_reg.idx_a, 1'b1)
                         + gterm(s3_r3_reg, s3_ctl_reg.idx_b, 1'b1));
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ctl_reg    <= ctl;
            s1_x1_reg     <= x1;
            s1_y1_reg     <= y1;
            s1_x2_reg     <= x2;
            s1_y2_reg     <= y2;
            s1_x3_reg     <= x3;
            s1_y3_reg     <= y3;
            s1_y4_reg     <= y4;
            s2_ctl_reg    <= s1_ctl_reg;
            s2_p1_reg     <= PW'(s1_x1_reg) * PW'(s1_y1_reg);
            s2_p2_reg     <= PW'(s1_x2_reg) * PW'(s1_y2_reg);
            s2_p3_reg     <= PW'(s1_x3_reg) * PW'(s1_y3_reg);
            s2_y4_reg     <= s1_y4_reg;
            s3_ctl_reg    <= s2_ctl_reg;
            s3_p4_reg     <= QW'(x4) * QW'(s2_y4_reg);
            s3_r1_reg     <= r1;
            s3_r2_reg     <= r2;
            s3_r3_reg     <= r3;
            out_node_reg  <= s3_ctl_reg.node;
            out_last_reg  <= s3_ctl_reg.last;
            out_shape_reg <= sat32(vfull);
            out_d0_reg    <= sat32(d0full);
            out_d1_reg    <= sat32(d1full);
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_node   = out_node_reg;
    assign m_last   = out_last_reg;
    assign m_shape  = out_shape_reg;
    assign m_deriv0 = out_d0_reg;
    assign m_deriv1 = out_d1_reg;

endmodule

### src/triangle_lagrange_shape_eval_top.sv
// Top level of the triangle Lagrange shape evaluator.
// Instantiates tlse_front, tlse_queue and tlse_back; uses tlse_pkg.
//
// Usage: each input beat on s_axis carries one parametric point (two signed
// Q1.16 coordinates). For every node of the configured element order the
// block sends one beat on m_axis with the node number, the shape value and
// its two partial derivatives (signed Q15.16, saturated); tlast marks the
// final node of the point. cfg_we writes element_order (0 and 1 linear,
// 2 quadratic, 3 cubic); the user must do so only while the block is idle, which the block does not enforce.
// Throughput: one result beat per cycle while the receiver keeps up; a point
// gives 3, 6 or 10 beats for linear, quadratic or cubic order, as set by the
// single multiply pipeline in the back end (one node per cycle unless stalled).
// Input passes the queue, operand, product, rounding and output registers.
// A two-entry queue holds accepted points, so input beats are taken while
// earlier points are still being evaluated or their results wait.
// When the receiver stalls, the output register holds its beat and the
// pipeline freezes; nothing is dropped. Reset clears the queue, pipeline and
// sets element_order to linear.
module triangle_lagrange_shape_eval_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [17:0] coord_first, [35:18] coord_second, [39:36] zero
    input  logic [39:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] node_index, [35:4] shape_value, [67:36] deriv_first,
    // [99:68] deriv_second, [103:100] zero
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int LW = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;
    localparam int EW = 2 + 36 + LW;

    logic          q_full, q_push, q_empty, q_pop;
    logic [EW-1:0] q_wdata, q_rdata;
    logic [3:0]    node;
    logic [31:0]   shape, deriv0, deriv1;

    tlse_front #(
        .FRAC_BITS(FRAC_BITS),
        .EW(EW)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .q_full(q_full),
        .q_push(q_push),
        .q_wdata(q_wdata)
    );

    tlse_queue #(
        .W(EW)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(q_push),
        .wdata(q_wdata),
        .full(q_full),
        .pop(q_pop),
        .rdata(q_rdata),
        .empty(q_empty)
    );

    tlse_back #(
        .FRAC_BITS(FRAC_BITS),
        .EW(EW)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .q_rdata(q_rdata),
        .q_pop(q_pop),
        .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready),
        .m_node(node),
        .m_shape(shape),
        .m_deriv0(deriv0),
        .m_deriv1(deriv1),
        .m_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, deriv1, deriv0, shape, node};

endmodule

### dv/tlse_checker.sv
// Checker for the triangle Lagrange shape evaluator: watches both streams,
// predicts node results per accepted point and compares them beat by beat.
// Depends on tlse_pkg for the element order codes.
module tlse_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending_nodes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 <<< FB;

    typedef struct {
        logic [3:0]  node;
        logic [31:0] shape;
        logic [31:0] dfirst;
        logic [31:0] dsecond;
        logic        last;
    } node_result_t;

    node_result_t expected_nodes[$];
    logic [1:0] order_reg;

    assign pending_nodes = expected_nodes.size();

    // Product rescaled by s bits, rounding half up (floor of shifted sum).
    function automatic longint round_mul(longint a, longint b, int s);
        longint p;
        p = a * b + (64'sd1 <<< (s - 1));
        return p >>> s;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic void push_node(int k, longint v, longint dx, longint dy, bit last);
        node_result_t r;
        r.node = k[3:0];
        r.shape = clamp32(v);
        r.dfirst = clamp32(dx);
        r.dsecond = clamp32(dy);
        r.last = last;
        expected_nodes.push_back(r);
    endfunction

    // Expand one point into its node results for the current order.
    function automatic void predict_point(logic [39:0] data);
        longint lc[3];
        longint gx[3], gy[3];
        int ea[6], eb[6];
        int ord, n;
        longint v, g, ga, gb, p12, p13, p23;
        gx = '{1, 0, -1};
        gy = '{0, 1, -1};
        ord = (order_reg == 2'd0) ? int'(tlse_pkg::ORDER_LINEAR) : int'(order_reg);
        n = (ord == tlse_pkg::ORDER_LINEAR) ? 3 : ((ord == tlse_pkg::ORDER_QUAD) ? 6 : 10);
        lc[0] = longint'($signed(data[17:0]));
        lc[1] = longint'($signed(data[35:18]));
        lc[2] = ONE - lc[0] - lc[1];
        for (int i = 0; i < 3; i++) begin
            if (ord == tlse_pkg::ORDER_LINEAR) begin
                v = lc[i];
                g = ONE;
            end else if (ord == tlse_pkg::ORDER_QUAD) begin
                v = round_mul(lc[i], 2 * lc[i] - ONE, FB);
                g = 4 * lc[i] - ONE;
            end else begin
                v = round_mul(round_mul(lc[i], 3 * lc[i] - ONE, FB), 3 * lc[i] - 2 * ONE, FB + 1);
                g = round_mul(lc[i], 27 * lc[i] - 18 * ONE, FB + 1) + ONE;
            end
            push_node(i, v, g * gx[i], g * gy[i], i == n - 1);
        end
        if (ord == tlse_pkg::ORDER_QUAD) begin
            ea = '{0, 1, 2, 0, 0, 0};
            eb = '{1, 2, 0, 0, 0, 0};
            for (int i = 0; i < 3; i++) begin
                v = 4 * round_mul(lc[ea[i]], lc[eb[i]], FB);
                ga = 4 * lc[eb[i]];
                gb = 4 * lc[ea[i]];
                push_node(3 + i, v, ga * gx[ea[i]] + gb * gx[eb[i]],
                          ga * gy[ea[i]] + gb * gy[eb[i]], i == 2);
            end
        end else if (ord == tlse_pkg::ORDER_CUBIC) begin
            ea = '{0, 1, 1, 2, 2, 0};
            eb = '{1, 0, 2, 1, 0, 2};
            for (int i = 0; i < 6; i++) begin
                v = round_mul(9 * round_mul(lc[ea[i]], lc[eb[i]], FB), 3 * lc[ea[i]] - ONE,
                              FB + 1);
                ga = round_mul(9 * lc[eb[i]], 6 * lc[ea[i]] - ONE, FB + 1);
                gb = round_mul(9 * lc[ea[i]], 3 * lc[ea[i]] - ONE, FB + 1);
                push_node(3 + i, v, ga * gx[ea[i]] + gb * gx[eb[i]],
                          ga * gy[ea[i]] + gb * gy[eb[i]], 1'b0);
            end
            p12 = round_mul(lc[0], lc[1], FB);
            p13 = round_mul(lc[0], lc[2], FB);
            p23 = round_mul(lc[1], lc[2], FB);
            push_node(9, 27 * round_mul(p12, lc[2], FB), 27 * (p23 - p12), 27 * (p13 - p12),
                      1'b1);
        end
    endfunction

    // Track the register, expand accepted points, compare result beats.
    always @(posedge aclk) begin
        node_result_t want;
        if (!aresetn) begin
            order_reg <= tlse_pkg::ORDER_LINEAR;
            expected_nodes.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) order_reg <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) predict_point(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_nodes.size() == 0) begin
                    $error("unexpected result beat, node_index %0d", m_axis_tdata[3:0]);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_nodes.pop_front();
                    if (want.node !== m_axis_tdata[3:0] || want.shape !== m_axis_tdata[35:4] ||
                        want.dfirst !== m_axis_tdata[67:36] ||
                        want.dsecond !== m_axis_tdata[99:68] || want.last !== m_axis_tlast)
                        fail_count <= fail_count + 1;
                    if (want.node !== m_axis_tdata[3:0])
                        $error("node_index expected %0d actual %0d", want.node,
                               m_axis_tdata[3:0]);
                    if (want.shape !== m_axis_tdata[35:4])
                        $error("shape_value expected %0d actual %0d", $signed(want.shape),
                               $signed(m_axis_tdata[35:4]));
                    if (want.dfirst !== m_axis_tdata[67:36])
                        $error("deriv_first expected %0d actual %0d", $signed(want.dfirst),
                               $signed(m_axis_tdata[67:36]));
                    if (want.dsecond !== m_axis_tdata[99:68])
                        $error("deriv_second expected %0d actual %0d", $signed(want.dsecond),
                               $signed(m_axis_tdata[99:68]));
                    if (want.last !== m_axis_tlast)
                        $error("last_node expected %0d actual %0d", want.last, m_axis_tlast);
                end
            end
        end
    end
endmodule

### dv/tb_triangle_lagrange_shape_eval_top.sv
// Testbench top for the triangle Lagrange shape evaluator: clock, reset,
// point stimulus, order changes and verdict. Uses tlse_pkg and tlse_checker.
module tb_triangle_lagrange_shape_eval_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending_nodes;
    bit           sink_idles = 1'b1;
    bit           long_hold = 1'b0;
    int           sink_gap = 0;
    int           quiet_cycles = 0;

    always #5 aclk = ~aclk;

    triangle_lagrange_shape_eval_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    tlse_checker u_checker (.*);

    // Coordinate with a bias toward the extremes and the unit points.
    function automatic logic [17:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 18'h1ffff;
            1: return 18'h20000;
            2: return 18'h10000;
            3: return 18'h00000;
            4: return 18'(-$urandom_range(0, 131072));
            5, 6, 7: return 18'($urandom_range(0, 65536));
            default: return 18'($urandom);
        endcase
    endfunction

    // Send one point, holding valid until the beat is taken. Valid stays up
    // afterwards so that a following beat can go out back to back.
    task automatic send_point(logic [17:0] c1, logic [17:0] c2, bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, c2, c1};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Stop sending, wait out all results, pad, then write the order.
    task automatic set_order(logic [1:0] ord);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_nodes != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= ord;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: random idle bursts, or one long hold-off on request.
    always @(posedge aclk) begin
        if (long_hold) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap != 0) begin
            m_axis_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (sink_idles && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            sink_gap <= $urandom_range(0, 14);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("tb_triangle_lagrange_shape_eval_top failed");
            $finish;
        end
    end

    initial begin
        logic [1:0] orders[4];
        orders = '{2'd0, tlse_pkg::ORDER_QUAD, tlse_pkg::ORDER_CUBIC, tlse_pkg::ORDER_LINEAR};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed points per order: corners, extremes, outside points.
        for (int o = 0; o < 4; o++) begin
            set_order(orders[o]);
            send_point(18'h00000, 18'h00000, 0);
            send_point(18'h10000, 18'h00000, 0);
            send_point(18'h00000, 18'h10000, 0);
            send_point(18'h1ffff, 18'h1ffff, 0);
            send_point(18'h20000, 18'h20000, 0);
            send_point(18'h05555, 18'h05555, 0);
        end

        // Long receiver hold-off while points keep coming.
        set_order(tlse_pkg::ORDER_CUBIC);
        fork
            begin
                long_hold = 1'b1;
                repeat (200) @(posedge aclk);
                long_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++) send_point(pick_coord(), pick_coord(), 0);
                s_axis_tvalid <= 1'b0;
            end
        join

        // Random phases across randomly chosen orders, the first one cubic.
        for (int ph = 0; ph < 8; ph++) begin
            set_order(ph == 0 ? tlse_pkg::ORDER_CUBIC : 2'($urandom_range(0, 3)));
            for (int i = 0; i < 30; i++) send_point(pick_coord(), pick_coord(), 1);
        end

        // Final stretch without idling on either side.
        sink_idles = 1'b0;
        set_order(tlse_pkg::ORDER_CUBIC);
        for (int i = 0; i < 30; i++) send_point(pick_coord(), pick_coord(), 0);
        s_axis_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_nodes != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_triangle_lagrange_shape_eval_top passed");
        else
            $display("tb_triangle_lagrange_shape_eval_top failed");
        $finish;
    end
endmodule

### triangle_lagrange_shape_eval_top.f
src/tlse_pkg.sv
src/tlse_queue.sv
src/tlse_front.sv
src/tlse_back.sv
src/triangle_lagrange_shape_eval_top.sv
dv/tlse_checker.sv
dv/tb_triangle_lagrange_shape_eval_top.sv
